/* rtl/core/fdwd_pkg.sv */
`default_nettype none
package fdwd_pkg;

    localparam int SAMPLES_PER_FRAME = 160;
    localparam int MAX_DELAY_FRAMES  = 64;
    localparam int CHANNELS          = 4;
    localparam int NUM_FIELDS        = 4;

    localparam int DATA_W     = 32;
    localparam int COEF_W     = 8;
    localparam int FRAMES_W   = 7;
    localparam int Q_SHIFT    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LPF_COEF_NEW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LPF_COEF_OLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SURROUND_ENABLE = 3'd5;

    localparam logic [COEF_W-1:0]   RST_FEEDBACK_GAIN = 8'd0;
    localparam logic [COEF_W-1:0]   RST_LPF_COEF_NEW  = 8'd128;
    localparam logic [COEF_W-1:0]   RST_LPF_COEF_OLD  = 8'd0;
    localparam logic [FRAMES_W-1:0] RST_DELAY_FRAMES  = 7'd1;

    typedef struct packed {
        logic clr;
        logic fb_en;
        logic mul_en;
        logic wb_en;
    } t_chan_ctrl;

endpackage
`default_nettype wire

/* rtl/core/fdwd_ram.sv */
`default_nettype none
module fdwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/fdwd_chan.sv */
`default_nettype none
module fdwd_chan (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fdwd_pkg::t_chan_ctrl                i_ctrl,
    input  wire logic [fdwd_pkg::DATA_W-1:0]         i_x,
    input  wire logic [fdwd_pkg::DATA_W-1:0]         i_d,
    input  wire logic [fdwd_pkg::COEF_W-1:0]         i_gain,
    input  wire logic [fdwd_pkg::COEF_W-1:0]         i_coef_new,
    input  wire logic [fdwd_pkg::COEF_W-1:0]         i_coef_old,
    output logic      [fdwd_pkg::DATA_W-1:0]         o_y
);

    localparam int DW = fdwd_pkg::DATA_W;
    localparam int PW = fdwd_pkg::DATA_W + fdwd_pkg::COEF_W;

    logic [DW-1:0] w_mag;
    logic [PW-1:0] w_fb_prod;
    logic [DW-1:0] w_fb_sh;
    logic [DW-1:0] w_fb_signed;
    logic [DW-1:0] n_fb;
    logic [PW-1:0] w_pn;
    logic [PW-1:0] w_po;
    logic [DW-1:0] w_sum;

    logic [DW-1:0] r_fb;
    logic [DW-1:0] r_pn;
    logic [DW-1:0] r_po;
    logic [DW-1:0] r_lp;

    // sign-magnitude scaling of the delayed sample
    always_comb begin
        w_mag       = i_d[DW-1] ? (DW'(0) - i_d) : i_d;
        w_fb_prod   = PW'(w_mag) * PW'(i_gain);
        w_fb_sh     = DW'($signed(w_fb_prod[DW-1:0]) >>> fdwd_pkg::Q_SHIFT);
        w_fb_signed = i_d[DW-1] ? (DW'(0) - w_fb_sh) : w_fb_sh;
        n_fb        = i_x - w_fb_signed;
    end

    assign w_pn  = PW'(r_fb) * PW'(i_coef_new);
    assign w_po  = PW'(r_lp) * PW'(i_coef_old);
    assign w_sum = r_pn + r_po;
    assign o_y   = DW'($signed(w_sum) >>> fdwd_pkg::Q_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fb_en) begin
            r_fb <= n_fb;
        end
        if (i_ctrl.mul_en) begin
            r_pn <= w_pn[DW-1:0];
            r_po <= w_po[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_lp <= '0;
        end else if (i_ctrl.wb_en) begin
            r_lp <= o_y;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/feedback_delay_with_damping_core.sv */
// A beat accepted in S_IDLE passes through S_FB (delay line read, feedback scale), S_MUL
// (damping products) and S_WB (write-back, held while the output is full) to o_m_axis_tvalid.
// No new beat is taken until the last one has left S_WB (read-modify-write of a delay RAM row).
// Reset (i_rst_n low, synchronous): registers take their reset values. The delay line needs
// no clearing pass: a fill count marks written rows, unwritten rows read as zero, and a
// write of 1 to enable while it is 0 restarts the fill count, position and lowpass state.
`default_nettype none
module feedback_delay_with_damping_core #(
    parameter int SAMPLES_PER_FRAME = fdwd_pkg::SAMPLES_PER_FRAME,
    parameter int MAX_DELAY_FRAMES  = fdwd_pkg::MAX_DELAY_FRAMES,
    parameter int CHANNELS          = fdwd_pkg::CHANNELS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // front_left_in, front_right_in, rear_left_in, rear_right_in
    input  wire logic [fdwd_pkg::NUM_FIELDS*fdwd_pkg::DATA_W-1:0] i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // front_left_out, front_right_out, rear_left_out, rear_right_out
    output logic      [fdwd_pkg::NUM_FIELDS*fdwd_pkg::DATA_W-1:0] o_m_axis_tdata,
    input  wire logic                                   i_cfg_we,
    input  wire logic [fdwd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [fdwd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DW       = fdwd_pkg::DATA_W;
    localparam int NF       = fdwd_pkg::NUM_FIELDS;
    localparam int CH_DEPTH = MAX_DELAY_FRAMES * SAMPLES_PER_FRAME;
    localparam int PW       = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
    localparam int LW       = $clog2(CH_DEPTH + 1);
    localparam int RW       = CHANNELS * DW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FB   = 4'b0010,
        S_MUL  = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                            r_enable;
    logic [fdwd_pkg::COEF_W-1:0]     r_gain;
    logic [fdwd_pkg::COEF_W-1:0]     r_coef_new;
    logic [fdwd_pkg::COEF_W-1:0]     r_coef_old;
    logic [fdwd_pkg::FRAMES_W-1:0]   r_delay_frames;
    logic                            r_surround;

    logic [PW-1:0] r_pos;
    logic [LW-1:0] r_fill;
    logic          r_rd_valid;
    logic [DW-1:0] r_x [NF];
    logic          r_ovalid;
    logic [NF*DW-1:0] r_odata;

    logic          w_accept;
    logic          w_out_free;
    logic          w_wb_go;
    logic          w_ram_we;
    logic          w_clr;
    logic [RW-1:0] w_rdata;
    logic [RW-1:0] w_wdata;
    logic [LW-1:0] w_frames;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_pos_inc;
    logic [PW-1:0] n_pos;
    logic [DW-1:0] w_d [NF];
    logic [DW-1:0] w_y [NF];
    logic [NF-1:0] w_proc;
    logic [NF*DW-1:0] n_odata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign w_wb_go         = (r_state == S_WB) && w_out_free;
    assign w_ram_we        = w_wb_go && r_enable;
    assign w_clr           = i_cfg_we && (i_cfg_idx == fdwd_pkg::REG_ENABLE)
                             && !r_enable && i_cfg_data[0];

    always_comb begin
        if (r_delay_frames == '0) begin
            w_frames = LW'(1);
        end else if (int'(r_delay_frames) > MAX_DELAY_FRAMES) begin
            w_frames = LW'(MAX_DELAY_FRAMES);
        end else begin
            w_frames = LW'(r_delay_frames);
        end
        w_len     = LW'(w_frames * LW'(SAMPLES_PER_FRAME));
        w_pos_inc = LW'(r_pos) + LW'(1);
        n_pos     = (w_pos_inc >= w_len) ? '0 : PW'(w_pos_inc);
    end

    fdwd_ram #(
        .WIDTH (RW),
        .DEPTH (CH_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    for (genvar c = 0; c < NF; c++) begin : g_lane
        if (c < CHANNELS) begin : g_proc
            fdwd_pkg::t_chan_ctrl w_ctrl;

            assign w_proc[c] = r_enable && ((c < 2) || r_surround);
            assign w_d[c]    = r_rd_valid ? w_rdata[c*DW +: DW] : '0;
            assign w_wdata[c*DW +: DW] = w_proc[c] ? w_y[c] : w_d[c];

            always_comb begin
                w_ctrl.clr    = w_clr;
                w_ctrl.fb_en  = (r_state == S_FB);
                w_ctrl.mul_en = (r_state == S_MUL);
                w_ctrl.wb_en  = w_ram_we && w_proc[c];
            end

            fdwd_chan u_chan (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_x        (r_x[c]),
                .i_d        (w_d[c]),
                .i_gain     (r_gain),
                .i_coef_new (r_coef_new),
                .i_coef_old (r_coef_old),
                .o_y        (w_y[c])
            );
        end else begin : g_pass
            assign w_proc[c] = 1'b0;
            assign w_d[c]    = r_x[c];
            assign w_y[c]    = r_x[c];
        end
        assign n_odata[c*DW +: DW] = w_proc[c] ? w_d[c] : r_x[c];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FB;
                end
            end
            S_FB:  n_state = S_MUL;
            S_MUL: n_state = S_WB;
            S_WB: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_enable       <= 1'b0;
            r_gain         <= fdwd_pkg::RST_FEEDBACK_GAIN;
            r_coef_new     <= fdwd_pkg::RST_LPF_COEF_NEW;
            r_coef_old     <= fdwd_pkg::RST_LPF_COEF_OLD;
            r_delay_frames <= fdwd_pkg::RST_DELAY_FRAMES;
            r_surround     <= 1'b1;
            r_pos          <= '0;
            r_fill         <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fdwd_pkg::REG_ENABLE:          r_enable <= i_cfg_data[0];
                    fdwd_pkg::REG_FEEDBACK_GAIN:   r_gain <= i_cfg_data;
                    fdwd_pkg::REG_LPF_COEF_NEW:    r_coef_new <= i_cfg_data;
                    fdwd_pkg::REG_LPF_COEF_OLD:    r_coef_old <= i_cfg_data;
                    fdwd_pkg::REG_DELAY_FRAMES:
                        r_delay_frames <= i_cfg_data[fdwd_pkg::FRAMES_W-1:0];
                    fdwd_pkg::REG_SURROUND_ENABLE: r_surround <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_clr) begin
                r_pos  <= '0;
                r_fill <= '0;
            end else if (w_ram_we) begin
                r_pos <= n_pos;
                if (LW'(r_pos) == r_fill) begin
                    r_fill <= r_fill + LW'(1);
                end
            end
            if (w_wb_go) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_valid <= (LW'(r_pos) < r_fill);
            for (int c = 0; c < NF; c++) begin
                r_x[c] <= i_s_axis_tdata[c*DW +: DW];
            end
        end
        if (w_wb_go) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_pos_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_pos) <= r_fill)
        else $error("delay position ahead of written rows");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(CH_DEPTH))
        else $error("fill count beyond delay depth");

    a_write_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_WB) && r_enable)
        else $error("delay RAM written outside write-back");

    a_clr_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr |=> (r_fill == '0) && (r_pos == '0))
        else $error("enable did not restart the delay line");

endmodule
`default_nettype wire
